// ----- design/great_circle_destination_macros.svh -----
// Assertion macros shared by the great circle destination design.
`ifndef GREAT_CIRCLE_DESTINATION_MACROS_SVH
`define GREAT_CIRCLE_DESTINATION_MACROS_SVH

// Same-cycle implication.
`define GCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gcd_pkg.sv -----
// Shared types, constants and helper functions for the great circle destination block.
package gcd_pkg;

    localparam int CW  = 34;   // CORDIC datapath width, signed Q30
    localparam int BW  = 32;   // binary angle width, full turn = 2^32

    localparam logic signed [CW-1:0] KINV_Q30      = 34'sd652032874;
    localparam logic [BW-1:0]        QUARTER_TURN  = 32'h4000_0000;
    localparam logic [BW-1:0]        HALF_TURN     = 32'h8000_0000;
    localparam logic [BW-1:0]        MINUS_QUARTER = 32'hC000_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [BW-1:0] lon;
        logic [BW-1:0] lat;
        logic [BW-1:0] az;
        logic [BW-1:0] arc;
    } t_item;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    // Rounded Q30 product.
    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        p = p + (2*CW)'(64'sd536870912);
        return CW'(p >>> 30);
    endfunction

    // atan(2^-i) as a binary angle.
    function automatic logic [BW-1:0] atan_tab(input logic [4:0] idx);
        logic [BW-1:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/great_circle_destination.sv -----
// Throughput: one word per cycle unless i_stall or a full queue holds the flow;
// every CORDIC iteration is its own pipeline stage.
// Front end (3 conversion stages) and back end (CORDIC chain) stall independently,
// with a 4-word queue between them; the back end stalls as a whole on i_stall.
// Reset (i_rst_n low, synchronous) empties all pipelines and the queue; data is not reset.
// The output word register holds its payload while i_stall is high.
`include "great_circle_destination_macros.svh"

module great_circle_destination #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [24:0]  i_start_lon,
    input  logic signed [23:0]  i_start_lat,
    input  logic [24:0]         i_azimuth,
    input  logic [23:0]         i_distance,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [24:0]  o_dest_lon,
    output logic signed [23:0]  o_dest_lat
);

    gcd_pkg::t_item   f_item, q_item;
    gcd_pkg::t_q_stat q_stat;
    logic             q_push, q_pop;

    // front: accept and convert to binary angles
    gcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_start_lon (i_start_lon),
        .i_start_lat (i_start_lat),
        .i_azimuth   (i_azimuth),
        .i_distance  (i_distance),
        .i_q_full    (q_stat.full),
        .o_push      (q_push),
        .o_item      (f_item)
    );

    // decoupling queue
    gcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // back: CORDIC datapath and output word register
    gcd_back #(.STEPS(CORDIC_STEPS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (q_item),
        .i_have     (!q_stat.empty),
        .o_pop      (q_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_dest_lon (o_dest_lon),
        .o_dest_lat (o_dest_lat)
    );

    // queue bookkeeping across front and back
    `GCD_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, q_push, !q_stat.full, "push into full queue")
    `GCD_ASSERT_IMPLY(a_pop_data, i_clk, i_rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `GCD_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count lost a push")

endmodule

// ----- design/gcd_dly.sv -----
// Enabled delay line for pipeline alignment.
module gcd_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// ----- design/gcd_rot.sv -----
// Pipelined rotation CORDIC: sine and cosine of a binary angle, one iteration per stage.
module gcd_rot #(
    parameter int STEPS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [gcd_pkg::BW-1:0]          i_ang,
    output logic signed [gcd_pkg::CW-1:0]   o_sin,
    output logic signed [gcd_pkg::CW-1:0]   o_cos
);

    localparam int CW = gcd_pkg::CW;
    localparam int BW = gcd_pkg::BW;
    localparam logic signed [BW-1:0] QT_POS = gcd_pkg::QUARTER_TURN;
    localparam logic signed [BW-1:0] QT_NEG = -QT_POS;

    logic signed [CW-1:0] sx [0:STEPS];
    logic signed [CW-1:0] sy [0:STEPS];
    logic signed [CW-1:0] sz [0:STEPS];
    logic                 sf [0:STEPS];

    logic signed [BW-1:0] ang_s;
    logic signed [BW-1:0] ang_h;
    logic                 flip0;

    // outside +-90 deg: rotate by half a turn and negate at the end
    always_comb begin
        ang_s = signed'(i_ang);
        ang_h = signed'(i_ang + gcd_pkg::HALF_TURN);
        flip0 = (ang_s > QT_POS) || (ang_s < QT_NEG);
        sz[0] = flip0 ? CW'(ang_h) : CW'(ang_s);
        sx[0] = gcd_pkg::KINV_Q30;
        sy[0] = '0;
        sf[0] = flip0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [CW-1:0] r_x, r_y, r_z;
        logic                 r_f;
        logic signed [CW-1:0] n_x, n_y, n_z;
        logic signed [CW-1:0] dx, dy, ta;

        always_comb begin
            dx = sy[i] >>> i;
            dy = sx[i] >>> i;
            ta = signed'(CW'(gcd_pkg::atan_tab(5'(i))));
            if (sz[i] >= 0) begin
                n_x = sx[i] - dx;
                n_y = sy[i] + dy;
                n_z = sz[i] - ta;
            end else begin
                n_x = sx[i] + dx;
                n_y = sy[i] - dy;
                n_z = sz[i] + ta;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_f <= sf[i];
            end
        end

        assign sx[i+1] = r_x;
        assign sy[i+1] = r_y;
        assign sz[i+1] = r_z;
        assign sf[i+1] = r_f;
    end

    assign o_sin = sf[STEPS] ? -sy[STEPS] : sy[STEPS];
    assign o_cos = sf[STEPS] ? -sx[STEPS] : sx[STEPS];

endmodule

// ----- design/gcd_vec.sv -----
// Pipelined vectoring CORDIC: atan2 and scaled magnitude, one iteration per stage.
module gcd_vec #(
    parameter int STEPS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [gcd_pkg::CW-1:0]   i_x,
    input  logic signed [gcd_pkg::CW-1:0]   i_y,
    output logic [gcd_pkg::BW-1:0]          o_ang,
    output logic signed [gcd_pkg::CW-1:0]   o_mag
);

    localparam int CW = gcd_pkg::CW;
    localparam int BW = gcd_pkg::BW;

    logic signed [CW-1:0] sx [0:STEPS];
    logic signed [CW-1:0] sy [0:STEPS];
    logic [BW-1:0]        sz [0:STEPS];
    logic                 s0 [0:STEPS];

    logic [BW-1:0]        r_ang;
    logic signed [CW-1:0] r_mag;

    // left half plane: pre-rotate by a quarter turn
    always_comb begin
        s0[0] = (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            if (i_y >= 0) begin
                sx[0] = i_y;
                sy[0] = -i_x;
                sz[0] = gcd_pkg::QUARTER_TURN;
            end else begin
                sx[0] = -i_y;
                sy[0] = i_x;
                sz[0] = gcd_pkg::MINUS_QUARTER;
            end
        end else begin
            sx[0] = i_x;
            sy[0] = i_y;
            sz[0] = '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [CW-1:0] r_x, r_y;
        logic [BW-1:0]        r_z;
        logic                 r_zero;
        logic signed [CW-1:0] n_x, n_y, dx, dy;
        logic [BW-1:0]        n_z, ta;

        always_comb begin
            dx = sy[i] >>> i;
            dy = sx[i] >>> i;
            ta = gcd_pkg::atan_tab(5'(i));
            if (sy[i] < 0) begin
                n_x = sx[i] - dx;
                n_y = sy[i] + dy;
                n_z = sz[i] - ta;
            end else begin
                n_x = sx[i] + dx;
                n_y = sy[i] - dy;
                n_z = sz[i] + ta;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_zero <= s0[i];
            end
        end

        assign sx[i+1] = r_x;
        assign sy[i+1] = r_y;
        assign sz[i+1] = r_z;
        assign s0[i+1] = r_zero;
    end

    // gain correction; zero vector gives zero angle and magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= s0[STEPS] ? '0 : sz[STEPS];
            r_mag <= s0[STEPS] ? '0 : gcd_pkg::qmul(sx[STEPS], gcd_pkg::KINV_Q30);
        end
    end

    assign o_ang = r_ang;
    assign o_mag = r_mag;

endmodule

// ----- design/gcd_front.sv -----
// Front end: accepts input words and converts degrees*65536 to binary angles.
module gcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [24:0]  i_start_lon,
    input  logic signed [23:0]  i_start_lat,
    input  logic [24:0]         i_azimuth,
    input  logic [23:0]         i_distance,
    input  logic                i_q_full,
    output logic                o_push,
    output gcd_pkg::t_item      o_item
);

    localparam int LANES = 4;
    localparam logic [25:0] RECIP_HI = 26'd47721859;  // ceil(2^31/45)
    localparam logic [19:0] RECIP_LO = 20'd745655;    // ceil(2^25/45)
    localparam logic [24:0] DIV45    = 25'd45;
    localparam logic [18:0] RND      = 19'd22;

    logic       adv;
    logic [2:0] r_v;

    logic [24:0] mag [LANES];
    logic        sgn [LANES];

    logic [19:0] r_s0_a   [LANES];
    logic [24:0] r_s0_mag [LANES];
    logic        r_s0_sgn [LANES];
    logic [19:0] r_s1_a   [LANES];
    logic [5:0]  r_s1_r   [LANES];
    logic        r_s1_sgn [LANES];
    logic [31:0] r_s2_bam [LANES];

    logic signed [25:0] lon_ext, lat_ext;

    assign adv     = !(r_v[2] && i_q_full);
    assign o_stall = r_v[2] && i_q_full;
    assign o_push  = r_v[2] && !i_q_full;

    always_comb begin
        lon_ext = 26'(i_start_lon);
        lat_ext = 26'(i_start_lat);
        sgn[0]  = i_start_lon[24];
        mag[0]  = 25'(sgn[0] ? -lon_ext : lon_ext);
        sgn[1]  = i_start_lat[23];
        mag[1]  = 25'(sgn[1] ? -lat_ext : lat_ext);
        sgn[2]  = 1'b0;
        mag[2]  = i_azimuth;
        sgn[3]  = 1'b0;
        mag[3]  = {1'b0, i_distance};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // q = 8192*floor(m/45) + floor((8192*(m mod 45) + 22)/45)
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [50:0] p_hi;
        logic [38:0] p_lo;
        logic [18:0] n_lo;
        logic [12:0] frac;
        logic [31:0] q;

        always_comb begin
            p_hi = 51'(mag[k]) * 51'(RECIP_HI);
            n_lo = {r_s1_r[k], 13'd0} + RND;
            p_lo = 39'(n_lo) * 39'(RECIP_LO);
            frac = 13'(p_lo >> 25);
            q    = {r_s1_a[k][18:0], frac};
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s0_a[k]   <= 20'(p_hi >> 31);
                r_s0_mag[k] <= mag[k];
                r_s0_sgn[k] <= sgn[k];
                r_s1_a[k]   <= r_s0_a[k];
                r_s1_r[k]   <= 6'(r_s0_mag[k] - 25'(r_s0_a[k]) * DIV45);
                r_s1_sgn[k] <= r_s0_sgn[k];
                r_s2_bam[k] <= r_s1_sgn[k] ? (32'd0 - q) : q;
            end
        end
    end

    assign o_item.lon = r_s2_bam[0];
    assign o_item.lat = r_s2_bam[1];
    assign o_item.az  = r_s2_bam[2];
    assign o_item.arc = r_s2_bam[3];

endmodule

// ----- design/gcd_queue.sv -----
// Short word queue between front and back ends.
module gcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gcd_pkg::t_item    i_item,
    input  logic              i_pop,
    output gcd_pkg::t_item    o_item,
    output gcd_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = gcd_pkg::QUEUE_DEPTH;

    gcd_pkg::t_item                  r_mem [0:DEPTH-1];
    logic [gcd_pkg::QIDX_W-1:0]      r_wr, r_rd;
    logic [gcd_pkg::QCNT_W-1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == gcd_pkg::QCNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

endmodule

// ----- design/gcd_back.sv -----
// Back end: CORDIC pipeline from binary angles to the destination point.
module gcd_back #(
    parameter int STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gcd_pkg::t_item      i_item,
    input  logic                i_have,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic signed [24:0]  o_dest_lon,
    output logic signed [23:0]  o_dest_lat
);

    localparam int CW = gcd_pkg::CW;
    localparam int BW = gcd_pkg::BW;
    localparam int R  = STEPS;          // rotation latency
    localparam int V  = STEPS + 1;      // vectoring latency
    localparam int LV = 2*R + 2 + 4*V;  // stages ahead of the output register
    localparam logic signed [25:0] LON_HALF  = 26'sd11796480;
    localparam logic signed [25:0] LAT_LIMIT = 26'sd5898240;
    localparam logic signed [37:0] DEG45     = 38'sd45;
    localparam logic [37:0]        RND13     = 38'd4096;

    function automatic logic signed [25:0] bam_to_deg(input logic [BW-1:0] b);
        logic signed [37:0] n;
        logic [37:0]        m;
        logic [37:0]        r;
        n = 38'(signed'(b)) * DEG45;
        m = (n < 0) ? 38'(-n) : 38'(n);
        r = (m + RND13) >> 13;
        return (n < 0) ? -26'(r) : 26'(r);
    endfunction

    logic adv;
    logic r_out_valid;
    logic signed [24:0] r_lon;
    logic signed [23:0] r_lat;
    logic [LV-1:0] r_vl;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && i_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl        <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vl        <= {r_vl[LV-2:0], i_have};
            r_out_valid <= r_vl[LV-1];
        end
    end

    // start azimuth and latitude
    logic signed [CW-1:0] saz, caz, sa, ca;
    gcd_rot #(.STEPS(STEPS)) u_rot_az  (.i_clk(i_clk), .i_en(adv), .i_ang(i_item.az),
                                        .o_sin(saz), .o_cos(caz));
    gcd_rot #(.STEPS(STEPS)) u_rot_lat (.i_clk(i_clk), .i_en(adv), .i_ang(i_item.lat),
                                        .o_sin(sa), .o_cos(ca));

    logic [BW-1:0] lon_d, dist_d;
    gcd_dly #(.WIDTH(BW), .DEPTH(2*R + 2 + 3*V)) u_dly_lon (
        .i_clk(i_clk), .i_en(adv), .i_d(i_item.lon), .o_q(lon_d));
    gcd_dly #(.WIDTH(BW), .DEPTH(R + 1 + V)) u_dly_dist (
        .i_clk(i_clk), .i_en(adv), .i_d(i_item.arc), .o_q(dist_d));

    logic signed [CW-1:0] r_p1, r_p2, r_p3, r_caz, r_sa;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1  <= gcd_pkg::qmul(saz, sa);
            r_p2  <= gcd_pkg::qmul(saz, ca);
            r_p3  <= gcd_pkg::qmul(ca, caz);
            r_caz <= caz;
            r_sa  <= sa;
        end
    end

    // equator crossing: heading there and offset along the circle
    logic signed [CW-1:0] m1;
    logic [BW-1:0]        dpe;
    gcd_vec #(.STEPS(STEPS)) u_vec_m1  (.i_clk(i_clk), .i_en(adv), .i_x(r_caz), .i_y(r_p1),
                                        .o_ang(), .o_mag(m1));
    gcd_vec #(.STEPS(STEPS)) u_vec_dpe (.i_clk(i_clk), .i_en(adv), .i_x(r_p3), .i_y(r_sa),
                                        .o_ang(dpe), .o_mag());

    logic [CW-1:0] p2_d;
    logic [BW-1:0] dpe_d, del_d;
    gcd_dly #(.WIDTH(CW), .DEPTH(V)) u_dly_p2 (
        .i_clk(i_clk), .i_en(adv), .i_d(r_p2), .o_q(p2_d));
    gcd_dly #(.WIDTH(BW), .DEPTH(V)) u_dly_dpe (
        .i_clk(i_clk), .i_en(adv), .i_d(dpe), .o_q(dpe_d));
    gcd_dly #(.WIDTH(BW), .DEPTH(V)) u_dly_del (
        .i_clk(i_clk), .i_en(adv), .i_d(dpe + dist_d), .o_q(del_d));

    logic [BW-1:0] azp;
    gcd_vec #(.STEPS(STEPS)) u_vec_azp (.i_clk(i_clk), .i_en(adv), .i_x(m1),
                                        .i_y(signed'(p2_d)), .o_ang(azp), .o_mag());

    logic signed [CW-1:0] sap, cap, sd, cd, sdl, cdl;
    gcd_rot #(.STEPS(STEPS)) u_rot_azp (.i_clk(i_clk), .i_en(adv), .i_ang(azp),
                                        .o_sin(sap), .o_cos(cap));
    gcd_rot #(.STEPS(STEPS)) u_rot_dpe (.i_clk(i_clk), .i_en(adv), .i_ang(dpe_d),
                                        .o_sin(sd), .o_cos(cd));
    gcd_rot #(.STEPS(STEPS)) u_rot_del (.i_clk(i_clk), .i_en(adv), .i_ang(del_d),
                                        .o_sin(sdl), .o_cos(cdl));

    logic signed [CW-1:0] r_q1, r_t, r_q3, r_cd, r_cdl;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q1  <= gcd_pkg::qmul(sap, sd);
            r_t   <= gcd_pkg::qmul(sap, sdl);
            r_q3  <= gcd_pkg::qmul(cap, sdl);
            r_cd  <= cd;
            r_cdl <= cdl;
        end
    end

    // longitude offsets and the magnitude for latitude
    logic [BW-1:0]        a1, a2;
    logic signed [CW-1:0] m2;
    gcd_vec #(.STEPS(STEPS)) u_vec_a1 (.i_clk(i_clk), .i_en(adv), .i_x(r_cd), .i_y(r_q1),
                                       .o_ang(a1), .o_mag());
    gcd_vec #(.STEPS(STEPS)) u_vec_a2 (.i_clk(i_clk), .i_en(adv), .i_x(r_cdl), .i_y(r_t),
                                       .o_ang(a2), .o_mag(m2));

    logic [CW-1:0] q3_d;
    logic [BW-1:0] rlon_d;
    gcd_dly #(.WIDTH(CW), .DEPTH(V)) u_dly_q3 (
        .i_clk(i_clk), .i_en(adv), .i_d(r_q3), .o_q(q3_d));
    gcd_dly #(.WIDTH(BW), .DEPTH(V)) u_dly_rlon (
        .i_clk(i_clk), .i_en(adv), .i_d(lon_d - a1 + a2), .o_q(rlon_d));

    logic [BW-1:0] rlat;
    gcd_vec #(.STEPS(STEPS)) u_vec_lat (.i_clk(i_clk), .i_en(adv), .i_x(m2),
                                        .i_y(signed'(q3_d)), .o_ang(rlat), .o_mag());

    // back to degrees; -180 maps to +180, latitude clamps at the poles
    logic signed [25:0] dlon, dlat, n_lon, n_lat;
    always_comb begin
        dlon = bam_to_deg(rlon_d);
        dlat = bam_to_deg(rlat);
        n_lon = dlon;
        if (dlon <= -LON_HALF || dlon > LON_HALF) begin
            n_lon = LON_HALF;
        end
        n_lat = dlat;
        if (dlat > LAT_LIMIT) begin
            n_lat = LAT_LIMIT;
        end else if (dlat < -LAT_LIMIT) begin
            n_lat = -LAT_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lon <= 25'(n_lon);
            r_lat <= 24'(n_lat);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_dest_lon = r_lon;
    assign o_dest_lat = r_lat;

endmodule

// ----- dv/tb_top.sv -----
// Testbench for great_circle_destination: fixed-point great-circle predictor and scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int  STEPS       = 24;
    localparam int  LATENCY     = 6*STEPS+10;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_ITEMS  = 450;
    localparam longint KINV     = 64'sd652032874;
    localparam bit [31:0] QTR   = 32'h4000_0000;
    localparam bit [31:0] HALF  = 32'h8000_0000;
    localparam bit [31:0] MQTR  = 32'hC000_0000;
    localparam longint LAT_MAX  = 5898240;
    localparam longint LON_MAX  = 11796480;

    typedef struct {
        logic signed [24:0] lon;
        logic signed [23:0] lat;
    } t_dest;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [24:0] i_start_lon = '0;
    logic signed [23:0] i_start_lat = '0;
    logic [24:0]        i_azimuth = '0;
    logic [23:0]        i_distance = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [24:0] o_dest_lon;
    logic signed [23:0] o_dest_lat;

    t_dest       dest_q[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit [31:0]   arc_tab[32];

    great_circle_destination #(.CORDIC_STEPS(STEPS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_start_lon (i_start_lon),
        .i_start_lat (i_start_lat),
        .i_azimuth   (i_azimuth),
        .i_distance  (i_distance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_dest_lon  (o_dest_lon),
        .o_dest_lat  (o_dest_lat)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        arc_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                    81, 41, 20, 10, 5, 3, 1, 1, 0};
    end

    // ---------------- predictor ----------------

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Rotation mode: sine and cosine of a binary angle, Q30.
    task automatic rot_sin_cos(input bit [31:0] ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'($signed(ang));
        x = KINV;
        y = 0;
        flip = 1'b0;
        if (z > longint'(QTR) || z < -longint'(QTR)) begin
            z = longint'($signed(ang + HALF));
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(arc_tab[i]);
            end else begin
                x += dx; y -= dy; z += longint'(arc_tab[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    // Vectoring mode: atan2(y, x) as binary angle, magnitude in Q30.
    task automatic vec_angle(input longint xi, input longint yi,
                             output bit [31:0] ang, output longint mag);
        longint x, y, t, dx, dy;
        bit [31:0] z;
        x = xi;
        y = yi;
        z = '0;
        if (x == 0 && y == 0) begin
            ang = '0;
            mag = 0;
        end else begin
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = QTR;
                end else begin
                    t = x; x = -y; y = t; z = MQTR;
                end
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y < 0) begin
                    x -= dx; y += dy; z -= arc_tab[i];
                end else begin
                    x += dx; y -= dy; z += arc_tab[i];
                end
            end
            mag = q30_mul(x, KINV);
            ang = z;
        end
    endtask

    function automatic bit [31:0] deg_to_angle(longint d);
        longint n, q;
        n = d * 8192;
        if (n >= 0) q = (n + 22) / 45;
        else q = -((-n + 22) / 45);
        return q[31:0];
    endfunction

    function automatic longint angle_to_deg(bit [31:0] b);
        longint n;
        n = longint'($signed(b)) * 45;
        if (n >= 0) return (n + 4096) >>> 13;
        return -((-n + 4096) >>> 13);
    endfunction

    task automatic predict_dest(input logic signed [24:0] lon_in,
                                input logic signed [23:0] lat_in,
                                input logic [24:0] az_in, input logic [23:0] dist_in,
                                output t_dest res);
        bit [31:0] lon, lat, az, arc, azp, dpe, crs, lonp, del, rlat, rlon;
        longint saz, caz, sa, ca, sap, cap, sd, cd, sdl, cdl, m, t, u, dlon, dlat;
        lon  = deg_to_angle(longint'(lon_in));
        lat  = deg_to_angle(longint'(lat_in));
        az   = deg_to_angle(longint'({1'b0, az_in}));
        arc  = deg_to_angle(longint'({1'b0, dist_in}));
        rot_sin_cos(az, saz, caz);
        rot_sin_cos(lat, sa, ca);
        // heading where the circle crosses the equator
        vec_angle(caz, q30_mul(saz, sa), crs, m);
        vec_angle(m, q30_mul(saz, ca), azp, t);
        // arc from the start back to the crossing, pole safe
        vec_angle(q30_mul(ca, caz), sa, dpe, t);
        rot_sin_cos(azp, sap, cap);
        rot_sin_cos(dpe, sd, cd);
        vec_angle(cd, q30_mul(sap, sd), crs, t);
        lonp = lon - crs;
        del = dpe + arc;
        rot_sin_cos(del, sdl, cdl);
        u = q30_mul(sap, sdl);
        vec_angle(cdl, u, crs, m);
        vec_angle(m, q30_mul(cap, sdl), rlat, t);
        vec_angle(cdl, u, crs, t);
        rlon = lonp + crs;
        dlon = angle_to_deg(rlon);
        if (dlon <= -LON_MAX) dlon = LON_MAX;
        if (dlon > LON_MAX) dlon = LON_MAX;
        dlat = angle_to_deg(rlat);
        if (dlat > LAT_MAX) dlat = LAT_MAX;
        if (dlat < -LAT_MAX) dlat = -LAT_MAX;
        res.lon = dlon[24:0];
        res.lat = dlat[23:0];
    endtask

    // ---------------- stimulus ----------------

    // Send one word; the sender runs in random bursts with random gaps.
    task automatic send_point(input logic signed [24:0] lon, input logic signed [23:0] lat,
                              input logic [24:0] az, input logic [23:0] arc);
        t_dest exp_d;
        int    gap;
        predict_dest(lon, lat, az, arc, exp_d);
        i_valid     <= 1'b1;
        i_start_lon <= lon;
        i_start_lat <= lat;
        i_azimuth   <= az;
        i_distance  <= arc;
        do @(posedge i_clk); while (o_stall);
        dest_q.push_back(exp_d);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_field_extremes();
        send_point(25'sd0, 24'sd0, 25'd0, 24'd0);
        send_point(-25'sd11796480, 24'sd0, 25'd0, 24'd0);
        send_point(25'sd11796480, -24'sd5898240, 25'd23592960, 24'd11796480);
        send_point(-25'sd11796480, 24'sd5898240, 25'd0, 24'd11796480);
        send_point(25'sd11796479, 24'sd1, 25'd1, 24'd1);
        // raw field extremes beyond the nominal range
        send_point(25'h1000000, 24'h800000, 25'h1FFFFFF, 24'hFFFFFF);
        send_point(25'sd16777215, 24'sd8388607, 25'd0, 24'd0);
    endtask

    task automatic test_headings();
        for (int k = 0; k < 8; k++)
            send_point(25'sd3276800, 24'sd2949120, 25'(k * 2949120), 24'd1966080);
    endtask

    task automatic test_special_cases();
        // starts at the poles
        send_point(25'sd0, 24'sd5898240, 25'd5898240, 24'd655360);
        send_point(25'sd6553600, -24'sd5898240, 25'd0, 24'd655360);
        // a path that lands on the antimeridian from the east
        send_point(-25'sd5898240, 24'sd0, 25'd17694720, 24'd5898240);
        send_point(25'sd5898240, 24'sd0, 25'd5898240, 24'd5898240);
        // along the equator: zero-vector atan2
        send_point(25'sd0, 24'sd0, 25'd5898240, 24'd0);
        // out-of-range latitude
        send_point(25'sd0, 24'sd7000000, 25'd1000000, 24'd300000);
        send_point(25'sd0, -24'sd7000000, 25'd9000000, 24'd300000);
    endtask

    task automatic test_random_points();
        logic signed [24:0] lon;
        logic signed [23:0] lat;
        logic [24:0]        az;
        logic [23:0]        arc;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                lon = 25'($urandom);
                lat = 24'($urandom);
                az  = 25'($urandom);
                arc = 24'($urandom);
            end else begin
                lon = 25'($signed($urandom_range(0, 23592960)) - 11796480);
                lat = 24'($signed($urandom_range(0, 11796480)) - 5898240);
                az  = 25'($urandom_range(0, 23592960));
                arc = 24'($urandom_range(0, 11796480));
            end
            send_point(lon, lat, az, arc);
        end
    endtask

    // ---------------- receiver and scoreboard ----------------

    // Stall pattern: quiet, heavy and choppy phases.
    int stall_mode = 0;
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  = $urandom_range(0, 2);
            stall_phase = $urandom_range(20, 300);
        end
        stall_phase--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (cycle_cnt % 5 < 2);
        endcase
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    endtask

    always @(posedge i_clk) begin
        t_dest want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dest_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = dest_q.pop_front();
                if (o_dest_lon !== want.lon) report_mismatch("dest_lon", o_dest_lon, want.lon);
                if (o_dest_lat !== want.lat) report_mismatch("dest_lat", o_dest_lat, want.lat);
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_cnt, dest_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_headings();
        test_special_cases();
        test_random_points();
        i_valid <= 1'b0;
        while (dest_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 50) @(posedge i_clk);
        $display("covered field extremes, eight headings, poles, antimeridian, bad latitudes");
        $display("and %0d random points; %0d words sent, %0d checked", RAND_ITEMS,
                 n_sent, n_checked);
        if (n_errors == 0 && dest_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
